FILE: hdl/dbsl_pkg.sv
// Shared types, constants and helper functions for the double-buffered slice looper.
// Used by dbsl_ctrl, dbsl_datapath and double_buffered_slice_looper_unit.
package dbsl_pkg;

    // Sample store geometry.
    localparam int DEPTH = 131072;
    localparam int PW    = $clog2(DEPTH);      // position / address width
    localparam int LW    = $clog2(DEPTH + 1);  // length width, holds DEPTH itself

    // Field widths from the interface.
    localparam int SAMPLE_W = 32;
    localparam int LEN_IN_W = 20;
    localparam int CMP_W    = (LW > LEN_IN_W) ? LW : LEN_IN_W;

    // Repeat slice arithmetic.
    localparam int KNOB_W      = 8;
    localparam int KNOB_CENTER = 64;
    localparam int N_MAX       = 128;
    localparam int N_W         = 8;
    localparam int NN_SHIFT    = 14;           // 128 * 128 = 2**14
    localparam int NN_W        = NN_SHIFT + 1;
    localparam int PROD_W      = LW + NN_W;
    localparam int SLICE_MIN   = 256;
    localparam int SUB_MIN     = 64;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_LOOP_MODE = 1'b0;
    localparam logic REG_RATE_KNOB = 1'b1;

    // Run state codes as reported on mode_status.
    localparam logic [1:0] RS_OFF     = 2'd0;
    localparam logic [1:0] RS_STANDBY = 2'd1;
    localparam logic [1:0] RS_PLAYING = 2'd2;

    typedef enum logic [1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_BEGIN   = 2'd1,
        ACT_END     = 2'd2,
        ACT_DISABLE = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]                 action;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic [LEN_IN_W-1:0]        loop_length;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [1:0]                 mode_status;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear;
        logic exec;
        logic mul_nn;
        logic mul_len;
        logic slice;
        logic base;
        logic read;
        logic done;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic play_path;
        logic need_slice;
        logic out_free;
    } sts_t;

    // Reduce a value below twice the depth into the store's address range.
    function automatic logic [PW-1:0] mod_depth(input logic [LW:0] x);
        logic [LW:0] r;
        begin
            r = (x >= (LW+1)'(DEPTH)) ? x - (LW+1)'(DEPTH) : x;
            return r[PW-1:0];
        end
    endfunction

endpackage

FILE: hdl/double_buffered_slice_looper_unit.sv
// Flow: the controller takes one request at a time; after acceptance it applies the request,
// then for playback reads the playing store, first recomputing a repeat-mode slice at a wrap
// (n*n, length product, clamp, base), and offers the result once the output register is free.
// A new request is accepted only after the previous result has been registered.
// Reset: synchronous, active low; afterwards both stores are zeroed, one entry per cycle
// over all DEPTH (131072) entries, before the first request is accepted.
module double_buffered_slice_looper_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dbsl_pkg::in_t                     s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dbsl_pkg::out_t                    m_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dbsl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dbsl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dbsl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic                          loop_mode_reg;
    logic [dbsl_pkg::KNOB_W-1:0]   rate_knob_reg;
    logic                          cfg_write;
    dbsl_pkg::cmd_t                cmd;
    dbsl_pkg::sts_t                sts;

    // Configuration registers on the APB port; paddr[2] picks the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_mode_reg <= 1'b0;
            rate_knob_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == dbsl_pkg::REG_LOOP_MODE) begin
                loop_mode_reg <= pwdata[0];
            end else begin
                rate_knob_reg <= pwdata[dbsl_pkg::KNOB_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == dbsl_pkg::REG_RATE_KNOB) begin
            prdata = dbsl_pkg::APB_DATA_W'(rate_knob_reg);
        end else begin
            prdata = dbsl_pkg::APB_DATA_W'(loop_mode_reg);
        end
    end

    dbsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dbsl_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .loop_mode (loop_mode_reg),
        .rate_knob (rate_knob_reg)
    );

endmodule

FILE: hdl/dbsl_ctrl.sv
// Sequencing state machine for the double-buffered slice looper.
// Depends on dbsl_pkg for the command and status structs.
module dbsl_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  dbsl_pkg::sts_t sts,
    output dbsl_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_EXEC    = 9'b000000100,
        ST_MUL_NN  = 9'b000001000,
        ST_MUL_LEN = 9'b000010000,
        ST_SLICE   = 9'b000100000,
        ST_BASE    = 9'b001000000,
        ST_READ    = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (!sts.play_path) begin
                    state_next = ST_DONE;
                end else if (sts.need_slice) begin
                    state_next = ST_MUL_NN;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_MUL_NN: begin
                cmd.mul_nn = 1'b1;
                state_next = ST_MUL_LEN;
            end
            ST_MUL_LEN: begin
                cmd.mul_len = 1'b1;
                state_next  = ST_SLICE;
            end
            ST_SLICE: begin
                cmd.slice  = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                cmd.base   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register; reset starts the store clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/dbsl_datapath.sv
// Datapath of the slice looper: sample stores, positions, slice arithmetic and output register.
// Depends on dbsl_pkg; driven by the command struct from dbsl_ctrl.
module dbsl_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dbsl_pkg::cmd_t                cmd,
    output dbsl_pkg::sts_t                sts,
    input  dbsl_pkg::in_t                 s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dbsl_pkg::out_t                m_item,
    input  logic                          loop_mode,
    input  logic [dbsl_pkg::KNOB_W-1:0]   rate_knob
);

    // Sample stores, left in the low half and right in the high half.
    logic [2*dbsl_pkg::SAMPLE_W-1:0] store_a_mem [dbsl_pkg::DEPTH];
    logic [2*dbsl_pkg::SAMPLE_W-1:0] store_b_mem [dbsl_pkg::DEPTH];
    logic [2*dbsl_pkg::SAMPLE_W-1:0] rdata_a_reg, rdata_b_reg;

    dbsl_pkg::in_t  in_reg, in_next;
    dbsl_pkg::out_t out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    logic [1:0]              run_state_reg, run_state_next;
    logic                    recording_reg, recording_next;
    logic                    latched_reg, latched_next;
    logic                    bank_reg, bank_next;
    logic [dbsl_pkg::PW-1:0] rec_pos_reg, rec_pos_next;
    logic [dbsl_pkg::PW-1:0] play_pos_reg, play_pos_next;
    logic [dbsl_pkg::LW-1:0] play_len_reg, play_len_next;
    logic [dbsl_pkg::PW-1:0] play_start_reg, play_start_next;
    logic [dbsl_pkg::LW-1:0] slice_len_reg, slice_len_next;
    logic [dbsl_pkg::PW-1:0] slice_off_reg, slice_off_next;
    logic [dbsl_pkg::PW-1:0] base_reg, base_next;
    logic [dbsl_pkg::PW-1:0] rd_addr_reg, rd_addr_next;
    logic [dbsl_pkg::PW-1:0] clr_addr_reg, clr_addr_next;
    logic [dbsl_pkg::NN_W-1:0]   nn_reg, nn_next;
    logic [dbsl_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                    play_reg, play_next;

    // Combinational helpers.
    logic                            play_path;
    logic                            rec_we;
    logic                            we_a, we_b;
    logic [dbsl_pkg::PW-1:0]         wr_addr;
    logic [2*dbsl_pkg::SAMPLE_W-1:0] wr_data;
    logic [2*dbsl_pkg::SAMPLE_W-1:0] packed_in;
    logic [2*dbsl_pkg::SAMPLE_W-1:0] play_data;
    logic [dbsl_pkg::PW-1:0]         rec_pos_inc;
    logic [dbsl_pkg::CMP_W-1:0]      len_ext;
    logic [dbsl_pkg::LW-1:0]         len_sat;
    logic [dbsl_pkg::PW-1:0]         start_new;
    logic signed [dbsl_pkg::KNOB_W:0] knob_diff;
    logic [dbsl_pkg::N_W-1:0]        n_val;
    logic [2*dbsl_pkg::N_W-1:0]      nn_full;
    logic [dbsl_pkg::LW:0]           quot;
    logic [dbsl_pkg::LW:0]           slice_lo;
    logic [dbsl_pkg::LW-1:0]         slice_calc;
    logic [dbsl_pkg::PW-1:0]         base_calc;
    logic [dbsl_pkg::LW-1:0]         pos_inc;
    logic [dbsl_pkg::LW-1:0]         sub_len;

    // Status toward the controller.
    assign play_path = (in_reg.action == dbsl_pkg::ACT_SAMPLE)
                    && (run_state_reg == dbsl_pkg::RS_PLAYING)
                    && (play_len_reg != '0);
    assign sts.play_path  = play_path;
    assign sts.need_slice = (play_pos_reg == '0) && latched_reg;
    assign sts.clear_last = (clr_addr_reg == dbsl_pkg::PW'(dbsl_pkg::DEPTH - 1));
    assign sts.out_free   = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // Arithmetic shared by the steps below.
    always_comb begin
        packed_in   = {in_reg.right_in, in_reg.left_in};
        rec_pos_inc = (rec_pos_reg == dbsl_pkg::PW'(dbsl_pkg::DEPTH - 1)) ?
                      '0 : rec_pos_reg + 1'b1;

        // Bar length saturated to the store depth, and where it starts.
        len_ext   = dbsl_pkg::CMP_W'(in_reg.loop_length);
        len_sat   = (len_ext >= dbsl_pkg::CMP_W'(dbsl_pkg::DEPTH)) ?
                    dbsl_pkg::LW'(dbsl_pkg::DEPTH) : dbsl_pkg::LW'(len_ext);
        start_new = dbsl_pkg::mod_depth((dbsl_pkg::LW+1)'(rec_pos_reg)
                    + (dbsl_pkg::LW+1)'(dbsl_pkg::DEPTH) - (dbsl_pkg::LW+1)'(len_sat));

        // Knob to n, clamped to 0..128.
        knob_diff = (dbsl_pkg::KNOB_W+1)'(dbsl_pkg::KNOB_CENTER)
                  - $signed({rate_knob[dbsl_pkg::KNOB_W-1], rate_knob});
        if (knob_diff < 0) begin
            n_val = '0;
        end else if (knob_diff > (dbsl_pkg::KNOB_W+1)'(dbsl_pkg::N_MAX)) begin
            n_val = dbsl_pkg::N_W'(dbsl_pkg::N_MAX);
        end else begin
            n_val = knob_diff[dbsl_pkg::N_W-1:0];
        end
        nn_full = (2*dbsl_pkg::N_W)'(n_val) * (2*dbsl_pkg::N_W)'(n_val);

        // Slice length from the product, clamped to 256..play_length.
        quot       = prod_reg[dbsl_pkg::PROD_W-1:dbsl_pkg::NN_SHIFT];
        slice_lo   = (quot < (dbsl_pkg::LW+1)'(dbsl_pkg::SLICE_MIN)) ?
                     (dbsl_pkg::LW+1)'(dbsl_pkg::SLICE_MIN) : quot;
        slice_calc = (slice_lo > {1'b0, play_len_reg}) ?
                     play_len_reg : slice_lo[dbsl_pkg::LW-1:0];
        base_calc  = dbsl_pkg::mod_depth((dbsl_pkg::LW+1)'(play_start_reg)
                     + (dbsl_pkg::LW+1)'(slice_off_reg));

        // Play position advance, wrapping at max(slice, 64).
        pos_inc = dbsl_pkg::LW'(play_pos_reg) + 1'b1;
        sub_len = (slice_len_reg < dbsl_pkg::LW'(dbsl_pkg::SUB_MIN)) ?
                  dbsl_pkg::LW'(dbsl_pkg::SUB_MIN) : slice_len_reg;

        play_data = bank_reg ? rdata_a_reg : rdata_b_reg;
    end

    // Next-state logic for every command.
    always_comb begin
        in_next         = in_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        run_state_next  = run_state_reg;
        recording_next  = recording_reg;
        latched_next    = latched_reg;
        bank_next       = bank_reg;
        rec_pos_next    = rec_pos_reg;
        play_pos_next   = play_pos_reg;
        play_len_next   = play_len_reg;
        play_start_next = play_start_reg;
        slice_len_next  = slice_len_reg;
        slice_off_next  = slice_off_reg;
        base_next       = base_reg;
        rd_addr_next    = rd_addr_reg;
        clr_addr_next   = clr_addr_reg;
        nn_next         = nn_reg;
        prod_next       = prod_reg;
        play_next       = play_reg;
        rec_we          = 1'b0;

        if (cmd.accept) begin
            in_next = s_item;
        end

        if (cmd.clear) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        // Apply the request to the looper state.
        if (cmd.exec) begin
            play_next = play_path;
            case (dbsl_pkg::action_t'(in_reg.action))
                dbsl_pkg::ACT_SAMPLE: begin
                    if (recording_reg && (play_path
                        || run_state_reg == dbsl_pkg::RS_STANDBY)) begin
                        rec_we       = 1'b1;
                        rec_pos_next = rec_pos_inc;
                    end
                    if (play_path) begin
                        if (play_pos_reg == '0) begin
                            if (!latched_reg) begin
                                slice_len_next = play_len_reg;
                                slice_off_next = '0;
                                base_next      = play_start_reg;
                                rd_addr_next   = play_start_reg;
                            end
                        end else begin
                            rd_addr_next = dbsl_pkg::mod_depth(
                                (dbsl_pkg::LW+1)'(base_reg)
                                + (dbsl_pkg::LW+1)'(play_pos_reg));
                        end
                    end
                end
                dbsl_pkg::ACT_BEGIN: begin
                    latched_next = loop_mode;
                    if (recording_reg && in_reg.loop_length != '0) begin
                        play_len_next   = len_sat;
                        play_start_next = start_new;
                        base_next       = start_new;
                        bank_next       = ~bank_reg;
                        play_pos_next   = '0;
                        rec_pos_next    = '0;
                        slice_len_next  = len_sat;
                        slice_off_next  = '0;
                        run_state_next  = dbsl_pkg::RS_PLAYING;
                    end else begin
                        bank_next      = 1'b0;
                        rec_pos_next   = '0;
                        recording_next = 1'b1;
                        if (run_state_reg != dbsl_pkg::RS_PLAYING) begin
                            run_state_next = dbsl_pkg::RS_STANDBY;
                        end
                    end
                end
                dbsl_pkg::ACT_END: begin
                    play_pos_next = '0;
                    if (recording_reg) begin
                        recording_next = 1'b0;
                        rec_pos_next   = '0;
                    end
                    run_state_next = dbsl_pkg::RS_STANDBY;
                end
                dbsl_pkg::ACT_DISABLE: begin
                    if (run_state_reg == dbsl_pkg::RS_STANDBY) begin
                        run_state_next = dbsl_pkg::RS_OFF;
                        recording_next = 1'b0;
                    end
                end
                default: begin
                    play_next = 1'b0;
                end
            endcase
        end

        // Repeat slice: n*n, then length*n*n, then clamp.
        if (cmd.mul_nn) begin
            nn_next = nn_full[dbsl_pkg::NN_W-1:0];
        end
        if (cmd.mul_len) begin
            prod_next = dbsl_pkg::PROD_W'(play_len_reg) * dbsl_pkg::PROD_W'(nn_reg);
        end
        if (cmd.slice) begin
            slice_len_next = slice_calc;
            slice_off_next = dbsl_pkg::PW'(play_len_reg - slice_calc);
        end
        if (cmd.base) begin
            base_next    = base_calc;
            rd_addr_next = base_calc;
        end

        // The store read happens now; move the play position on.
        if (cmd.read) begin
            play_pos_next = (pos_inc >= sub_len) ? '0 : dbsl_pkg::PW'(pos_inc);
        end

        // Output register, freed when the downstream side takes it.
        if (cmd.done) begin
            out_valid_next        = 1'b1;
            out_next.mode_status  = run_state_reg;
            if (play_reg) begin
                out_next.left_out  = play_data[dbsl_pkg::SAMPLE_W-1:0];
                out_next.right_out = play_data[2*dbsl_pkg::SAMPLE_W-1:dbsl_pkg::SAMPLE_W];
            end else if (in_reg.action == dbsl_pkg::ACT_SAMPLE) begin
                out_next.left_out  = in_reg.left_in;
                out_next.right_out = in_reg.right_in;
            end else begin
                out_next.left_out  = '0;
                out_next.right_out = '0;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Store write port: zeros during the clearing pass, else the recorded sample.
    always_comb begin
        we_a    = cmd.clear || (rec_we && !bank_reg);
        we_b    = cmd.clear || (rec_we && bank_reg);
        wr_addr = cmd.clear ? clr_addr_reg : rec_pos_reg;
        wr_data = cmd.clear ? '0 : packed_in;
    end

    always_ff @(posedge aclk) begin
        if (we_a) begin
            store_a_mem[wr_addr] <= wr_data;
        end
        if (cmd.read) begin
            rdata_a_reg <= store_a_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            store_b_mem[wr_addr] <= wr_data;
        end
        if (cmd.read) begin
            rdata_b_reg <= store_b_mem[rd_addr_reg];
        end
    end

    // Looper state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            run_state_reg  <= dbsl_pkg::RS_OFF;
            recording_reg  <= 1'b0;
            latched_reg    <= 1'b0;
            bank_reg       <= 1'b0;
            rec_pos_reg    <= '0;
            play_pos_reg   <= '0;
            play_len_reg   <= '0;
            play_start_reg <= '0;
            slice_len_reg  <= '0;
            slice_off_reg  <= '0;
            base_reg       <= '0;
            clr_addr_reg   <= '0;
            play_reg       <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            run_state_reg  <= run_state_next;
            recording_reg  <= recording_next;
            latched_reg    <= latched_next;
            bank_reg       <= bank_next;
            rec_pos_reg    <= rec_pos_next;
            play_pos_reg   <= play_pos_next;
            play_len_reg   <= play_len_next;
            play_start_reg <= play_start_next;
            slice_len_reg  <= slice_len_next;
            slice_off_reg  <= slice_off_next;
            base_reg       <= base_next;
            clr_addr_reg   <= clr_addr_next;
            play_reg       <= play_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        out_reg     <= out_next;
        rd_addr_reg <= rd_addr_next;
        nn_reg      <= nn_next;
        prod_reg    <= prod_next;
    end

endmodule

FILE: sim/double_buffered_slice_looper_unit_test.sv
// Self-checking testbench for double_buffered_slice_looper_unit: a queue-fed request driver,
// a result monitor and a behavioral looper predictor checked field by field.
// Depends on dbsl_pkg (request/result types, store geometry, register and state codes).
module double_buffered_slice_looper_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime HALF_PERIOD   = 1.0;
    localparam int      SETTLE_CYCLES = 16;
    localparam int      PHASES        = 4;
    localparam int      PHASE_ITEMS   = 475;
    localparam int      LONG_HOLD     = 400;

    // Block ports.
    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    dbsl_pkg::in_t                   s_item  = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    dbsl_pkg::out_t                  m_item;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [dbsl_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [dbsl_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [dbsl_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Request and result bookkeeping.
    dbsl_pkg::in_t  request_fifo[$];
    dbsl_pkg::out_t expected_results[$];
    int unsigned queued_total     = 0;
    int unsigned requests_done    = 0;
    int unsigned results_seen     = 0;
    int unsigned error_count      = 0;
    int unsigned played_samples   = 0;
    int unsigned slice_recomputes = 0;

    // Flow control knobs, set by the sequencer and read at the clock edge.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit send_paused    = 1'b0;
    bit hold_go        = 1'b0;
    bit hold_loaded    = 1'b0;
    int hold_left      = 0;

    // Predicted looper state; the two-state arrays start cleared like the block after reset.
    bit [63:0]                        sample_store [2][dbsl_pkg::DEPTH];
    bit                               rec_bank;
    bit                               rec_active;
    bit                               mode_latched;
    bit [dbsl_pkg::PW-1:0]            rec_pos;
    bit [dbsl_pkg::PW-1:0]            play_pos;
    bit [dbsl_pkg::PW-1:0]            play_start;
    bit [dbsl_pkg::PW-1:0]            slice_off;
    bit [dbsl_pkg::LW-1:0]            play_len;
    bit [dbsl_pkg::LW-1:0]            slice_len;
    bit [1:0]                         run_state = dbsl_pkg::RS_OFF;
    bit                               cfg_repeat;
    bit signed [dbsl_pkg::KNOB_W-1:0] cfg_knob;

    int phase_send_idle  [PHASES] = '{0, 64, 0, 27};
    int phase_recv_stall [PHASES] = '{0, 0, 64, 27};

    double_buffered_slice_looper_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Write one stereo sample into the recording store and advance around the ring.
    function automatic void store_sample(bit [63:0] word);
        sample_store[rec_bank][rec_pos] = word;
        rec_pos = rec_pos + 1'b1;
    endfunction

    // Repeat slice: bar * n * n / 16384 with n = 64 - knob, kept within 256..bar.
    function automatic bit [dbsl_pkg::LW-1:0] repeat_slice_len(bit [dbsl_pkg::LW-1:0] bar);
        int              n;
        longint unsigned span;
        n = dbsl_pkg::KNOB_CENTER - int'(cfg_knob);
        if (n < 0) n = 0;
        if (n > dbsl_pkg::N_MAX) n = dbsl_pkg::N_MAX;
        span = (longint'(bar) * longint'(n * n)) >> dbsl_pkg::NN_SHIFT;
        if (span < dbsl_pkg::SLICE_MIN) span = dbsl_pkg::SLICE_MIN;
        if (span > bar) span = bar;
        return span[dbsl_pkg::LW-1:0];
    endfunction

    // Advance the predicted looper by one request and return the result it should produce.
    function automatic dbsl_pkg::out_t looper_step(dbsl_pkg::in_t req);
        dbsl_pkg::out_t        res;
        bit [63:0]             word;
        bit [dbsl_pkg::PW-1:0] rd_addr;
        bit [dbsl_pkg::LW-1:0] wrap_at;
        bit [dbsl_pkg::LW-1:0] next_pos;
        res = '0;
        case (dbsl_pkg::action_t'(req.action))
            dbsl_pkg::ACT_SAMPLE: begin
                word = {req.right_in, req.left_in};
                if (run_state == dbsl_pkg::RS_PLAYING && play_len != 0) begin
                    if (rec_active) store_sample(word);
                    // A new slice is chosen each time playback wraps to its start.
                    if (play_pos == 0) begin
                        if (mode_latched) begin
                            slice_len = repeat_slice_len(play_len);
                            slice_off = dbsl_pkg::PW'(play_len - slice_len);
                            slice_recomputes++;
                        end else begin
                            slice_len = play_len;
                            slice_off = '0;
                        end
                    end
                    rd_addr = dbsl_pkg::PW'(play_start + slice_off + play_pos);
                    word = sample_store[rec_bank ^ 1'b1][rd_addr];
                    res.left_out  = word[31:0];
                    res.right_out = word[63:32];
                    wrap_at  = (slice_len < dbsl_pkg::SUB_MIN) ?
                               dbsl_pkg::LW'(dbsl_pkg::SUB_MIN) : slice_len;
                    next_pos = dbsl_pkg::LW'(play_pos) + 1'b1;
                    play_pos = (next_pos >= wrap_at) ? '0 : next_pos[dbsl_pkg::PW-1:0];
                    played_samples++;
                end else begin
                    if (run_state == dbsl_pkg::RS_STANDBY && rec_active) store_sample(word);
                    res.left_out  = req.left_in;
                    res.right_out = req.right_in;
                end
            end
            dbsl_pkg::ACT_BEGIN: begin
                mode_latched = cfg_repeat;
                if (rec_active && req.loop_length != 0) begin
                    // Capture the last bar and swap the stores.
                    play_len   = (req.loop_length < dbsl_pkg::DEPTH) ?
                                 dbsl_pkg::LW'(req.loop_length) :
                                 dbsl_pkg::LW'(dbsl_pkg::DEPTH);
                    play_start = dbsl_pkg::PW'(rec_pos - play_len);
                    rec_bank   = rec_bank ^ 1'b1;
                    play_pos   = '0;
                    rec_pos    = '0;
                    slice_len  = play_len;
                    slice_off  = '0;
                    run_state  = dbsl_pkg::RS_PLAYING;
                end else begin
                    rec_bank   = 1'b0;
                    rec_pos    = '0;
                    rec_active = 1'b1;
                    if (run_state != dbsl_pkg::RS_PLAYING) run_state = dbsl_pkg::RS_STANDBY;
                end
            end
            dbsl_pkg::ACT_END: begin
                play_pos = '0;
                if (rec_active) begin
                    rec_active = 1'b0;
                    rec_pos    = '0;
                end
                run_state = dbsl_pkg::RS_STANDBY;
            end
            dbsl_pkg::ACT_DISABLE: begin
                if (run_state == dbsl_pkg::RS_STANDBY) begin
                    run_state  = dbsl_pkg::RS_OFF;
                    rec_active = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.mode_status = run_state;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $error("%s mismatch: expected %h, got %h", name, want, got);
        end
    endfunction

    // Request driver: predicts each accepted request, then offers the next one when free.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(looper_step(s_item));
                requests_done++;
            end
            if (!s_valid || s_ready) begin
                if (request_fifo.size() != 0 && !send_paused &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item  <= request_fifo.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        dbsl_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $error("result with no request outstanding: %p", m_item);
                end else begin
                    want = expected_results.pop_front();
                    check_field("left_out", want.left_out, m_item.left_out);
                    check_field("right_out", want.right_out, m_item.right_out);
                    check_field("mode_status", 32'(want.mode_status),
                                32'(m_item.mode_status));
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, loaded once when asked for and counted down one cycle at a time.
    always @(posedge aclk) begin
        if (hold_go && !hold_loaded) begin
            hold_left   <= LONG_HOLD;
            hold_loaded <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    function automatic void push_req(dbsl_pkg::in_t r);
        request_fifo.push_back(r);
        queued_total++;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [dbsl_pkg::LEN_IN_W-1:0] rand_len();
        return dbsl_pkg::LEN_IN_W'($urandom());
    endfunction

    function automatic dbsl_pkg::in_t make_req(dbsl_pkg::action_t act,
                                               logic [dbsl_pkg::LEN_IN_W-1:0] len);
        dbsl_pkg::in_t r;
        r.action      = act;
        r.left_in     = rand_sample();
        r.right_in    = rand_sample();
        r.loop_length = len;
        return r;
    endfunction

    function automatic dbsl_pkg::in_t make_sample(logic [31:0] l, logic [31:0] r);
        dbsl_pkg::in_t q;
        q = make_req(dbsl_pkg::ACT_SAMPLE, rand_len());
        q.left_in  = l;
        q.right_in = r;
        return q;
    endfunction

    // One take: stop, start recording, capture a bar, play it, then leave some way.
    task automatic queue_take();
        int rec_n;
        int bar;
        int play_n;
        int pick;
        pick   = $urandom_range(99);
        rec_n  = $urandom_range(90, 1);
        play_n = $urandom_range(120, 1);
        if (pick < 45) begin
            bar = $urandom_range(rec_n, 1);
        end else if (pick < 68) begin
            bar = $urandom_range(rec_n + 200, rec_n + 1);
        end else if (pick < 90) begin
            // Bars past the slice floor so that repeat slices are cut and recomputed.
            bar    = $urandom_range(420, dbsl_pkg::SLICE_MIN + 1);
            play_n = $urandom_range(480, dbsl_pkg::SLICE_MIN + 8);
        end else begin
            bar    = $urandom_range((1 << dbsl_pkg::LEN_IN_W) - 1, dbsl_pkg::DEPTH - 64);
            play_n = $urandom_range(24, 1);
        end
        push_req(make_req(dbsl_pkg::ACT_END, rand_len()));
        push_req(make_req(dbsl_pkg::ACT_BEGIN, '0));
        repeat (rec_n) push_req(make_sample(rand_sample(), rand_sample()));
        push_req(make_req(dbsl_pkg::ACT_BEGIN, dbsl_pkg::LEN_IN_W'(bar)));
        for (int i = 0; i < play_n; i++) begin
            pick = $urandom_range(199);
            if (pick == 0)
                push_req(make_req(dbsl_pkg::ACT_BEGIN,
                                  dbsl_pkg::LEN_IN_W'($urandom_range(rec_n + i, 1))));
            else if (pick == 1)
                push_req(make_req(dbsl_pkg::ACT_BEGIN, '0));
            else if (pick == 2)
                push_req(make_req(dbsl_pkg::ACT_DISABLE, rand_len()));
            else
                push_req(make_sample(rand_sample(), rand_sample()));
        end
        pick = $urandom_range(99);
        if (pick >= 60) begin
            push_req(make_req(dbsl_pkg::ACT_END, rand_len()));
            if (pick < 80) push_req(make_req(dbsl_pkg::ACT_DISABLE, rand_len()));
            repeat ($urandom_range(6)) push_req(make_sample(rand_sample(), rand_sample()));
        end
    endtask

    // Fill one phase: mostly complete takes, with raw random requests as noise.
    task automatic queue_phase(int unsigned count);
        dbsl_pkg::in_t noise;
        int unsigned   target;
        target = queued_total + count;
        while (queued_total < target) begin
            if ($urandom_range(99) < 85) begin
                queue_take();
            end else begin
                noise.action      = 2'($urandom());
                noise.left_in     = $urandom();
                noise.right_in    = $urandom();
                noise.loop_length = rand_len();
                push_req(noise);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (request_fifo.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic reg_index,
                             input logic [dbsl_pkg::APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dbsl_pkg::APB_ADDR_W'({reg_index, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_controls(bit repeat_mode, int knob);
        apb_write(dbsl_pkg::REG_LOOP_MODE, dbsl_pkg::APB_DATA_W'(repeat_mode));
        apb_write(dbsl_pkg::REG_RATE_KNOB, dbsl_pkg::APB_DATA_W'(knob));
        cfg_repeat = repeat_mode;
        cfg_knob   = dbsl_pkg::KNOB_W'(knob);
        @(negedge aclk);
    endtask

    // Run time limit.
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sequencer: reset, directed requests, then random phases under varied flow control.
    initial begin
        int unsigned base;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        set_controls(1'b0, 0);

        // Directed: off, standby, begin with zero and saturated lengths, ignored disables.
        push_req(make_sample(32'h8000_0000, 32'h7FFF_FFFF));
        push_req(make_req(dbsl_pkg::ACT_DISABLE, '1));
        push_req(make_req(dbsl_pkg::ACT_END, '0));
        push_req(make_sample(32'h7FFF_FFFF, 32'h8000_0000));
        push_req(make_req(dbsl_pkg::ACT_BEGIN, '1));
        push_req(make_sample(32'h8000_0000, 32'h8000_0000));
        push_req(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_req(make_sample('1, '0));
        push_req(make_sample(32'h5555_5555, 32'hAAAA_AAAA));
        push_req(make_req(dbsl_pkg::ACT_BEGIN, dbsl_pkg::LEN_IN_W'(3)));
        repeat (5) push_req(make_sample($urandom(), $urandom()));
        push_req(make_req(dbsl_pkg::ACT_BEGIN, '0));
        push_req(make_req(dbsl_pkg::ACT_DISABLE, '0));
        push_req(make_sample($urandom(), $urandom()));
        push_req(make_req(dbsl_pkg::ACT_BEGIN, '1));
        repeat (2) push_req(make_sample($urandom(), $urandom()));
        push_req(make_req(dbsl_pkg::ACT_END, '1));
        push_req(make_req(dbsl_pkg::ACT_DISABLE, '1));
        push_req(make_sample('0, '1));
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_controls(1'b1, -dbsl_pkg::KNOB_CENTER);
                1: set_controls(1'b1, dbsl_pkg::KNOB_CENTER);
                2: set_controls(1'b0, 23);
                default: set_controls(1'b1, int'($urandom_range(2 * dbsl_pkg::KNOB_CENTER))
                                            - dbsl_pkg::KNOB_CENTER);
            endcase
            send_idle_pct  = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            base = requests_done;
            queue_phase(PHASE_ITEMS);
            if (p == 0) begin
                // Hold the result side off long enough to back up the input.
                while (requests_done < base + 40 && request_fifo.size() != 0) @(negedge aclk);
                hold_go = 1'b1;
            end else if (p == 1) begin
                // Pause the sender until every outstanding result has drained.
                while (requests_done < base + 100 && request_fifo.size() != 0) @(negedge aclk);
                send_paused = 1'b1;
                do @(negedge aclk);
                while (s_valid || expected_results.size() != 0);
                send_paused = 1'b0;
            end
            wait_idle();
        end

        $display("Checked %0d results from %0d requests over 5 register settings.",
                 results_seen, requests_done);
        $display("Playback produced %0d stored samples; %0d repeat slices were recomputed.",
                 played_samples, slice_recomputes);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
